[hdl/fbr_pkg.sv]
package fbr_pkg;

    // Frame status codes reported with every echoed byte.
    typedef enum logic [2:0] {
        ST_PROGRESS = 3'd0,
        ST_GOOD     = 3'd1,
        ST_HDR_CRC  = 3'd2,
        ST_BODY_CRC = 3'd3,
        ST_BAD_ADDR = 3'd4,
        ST_SHORT    = 3'd5,
        ST_OVERFLOW = 3'd6
    } status_t;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SYNC_VALUE  = 2'd0;
    localparam logic [1:0] CFG_HDR_SEED    = 2'd1;
    localparam logic [1:0] CFG_BODY_SEED   = 2'd2;
    localparam logic [1:0] CFG_ADDR_LIMIT  = 2'd3;

    // Configuration reset values.
    localparam logic [7:0]  RST_SYNC_VALUE = 8'h3D;
    localparam logic [7:0]  RST_HDR_SEED   = 8'h66;
    localparam logic [15:0] RST_BODY_SEED  = 16'h913D;
    localparam logic [7:0]  RST_ADDR_LIMIT = 8'd16;

    // Frame layout.
    localparam logic [6:0] POS_ADDR   = 7'd1;
    localparam logic [6:0] POS_BODY   = 7'd2;
    localparam logic [6:0] POS_LEN    = 7'd3;
    localparam logic [6:0] POS_HCRC   = 7'd4;
    localparam logic [7:0] MIN_LENGTH = 8'd5;

    // CRC polynomials, no reflection and no final xor.
    localparam logic [7:0]  POLY8  = 8'h39;
    localparam logic [15:0] POLY16 = 16'h1021;

    typedef struct packed {
        logic [7:0]  sync_value;
        logic [7:0]  header_crc_seed;
        logic [15:0] body_crc_seed;
        logic [7:0]  address_limit;
    } cfg_t;

    // One queued byte with its classification.
    typedef struct packed {
        logic [7:0] data;
        logic       is_sync;
    } q_entry_t;

    function automatic logic [7:0] crc8_add(input logic [7:0] c, input logic [7:0] d);
        logic [7:0] v;
        v = c ^ d;
        for (int k = 0; k < 8; k++) begin
            v = v[7] ? ({v[6:0], 1'b0} ^ POLY8) : {v[6:0], 1'b0};
        end
        return v;
    endfunction

    function automatic logic [15:0] crc16_add(input logic [15:0] c, input logic [7:0] d);
        logic [15:0] v;
        v = c ^ {d, 8'h00};
        for (int k = 0; k < 8; k++) begin
            v = v[15] ? ({v[14:0], 1'b0} ^ POLY16) : {v[14:0], 1'b0};
        end
        return v;
    endfunction

endpackage

[hdl/fbr_front.sv]
module fbr_front
    import fbr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // rx_byte
    input  logic [7:0] sync_value,
    output logic       q_valid,
    output q_entry_t   q_entry,
    input  logic       q_ready
);

    q_entry_t   slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;

    // Two-entry queue between the input side and the frame engine.
    assign s_axis_tready = (count_reg != 2'd2);
    assign q_valid       = (count_reg != 2'd0);
    assign q_entry       = slot_reg[rd_ptr_reg];
    assign push          = s_axis_tvalid && s_axis_tready;
    assign pop           = q_valid && q_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Classify each byte as it is stored: does it match the sync value?
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg].data    <= s_axis_tdata;
            slot_reg[wr_ptr_reg].is_sync <= (s_axis_tdata == sync_value);
        end
    end

endmodule

[hdl/fbr_back.sv]
module fbr_back
    import fbr_pkg::*;
#(
    parameter int MAX_FRAME = 100
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       q_valid,
    input  q_entry_t   q_entry,
    output logic       q_ready,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic [6:0] out_pos,
    output logic       out_end,
    output status_t    out_status,
    output logic [7:0] out_len
);

    localparam logic [7:0] MAX_LEN = 8'(MAX_FRAME);

    logic [6:0]  byte_index_reg;
    logic [6:0]  byte_index_next;
    logic [7:0]  exp_len_reg;
    logic [7:0]  exp_len_next;
    logic [7:0]  hcrc_reg;
    logic [7:0]  hcrc_next;
    logic [15:0] bcrc_reg;
    logic [15:0] bcrc_next;
    logic [7:0]  held0_reg;
    logic [7:0]  held0_next;
    logic [7:0]  held1_reg;
    logic [7:0]  held1_next;
    logic [7:0]  addr_reg;
    logic [7:0]  addr_next;

    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic [6:0]  out_pos_reg;
    logic        out_end_reg;
    status_t     out_status_reg;
    logic [7:0]  out_len_reg;

    logic        hunting;
    logic        drop;
    logic        take;
    logic        load;
    logic [7:0]  b;
    logic [7:0]  next_pos;
    logic [7:0]  exp_new;
    logic [7:0]  crc8_val;
    logic [15:0] crc16_val;
    logic        res_end;
    status_t     res_status;
    logic [7:0]  res_len;

    // A non-sync byte while hunting is consumed without a result.
    assign hunting = (byte_index_reg == 7'd0);
    assign drop    = hunting && !q_entry.is_sync;
    assign q_ready = !out_valid_reg || out_ready || drop;
    assign take    = q_valid && q_ready;
    assign load    = take && !drop;
    assign b       = q_entry.data;
    assign next_pos = {1'b0, byte_index_reg} + 8'd1;

    // Per-byte CRC updates, one byte per cycle while the output does not stall.
    assign crc8_val  = crc8_add(hunting ? cfg.header_crc_seed : hcrc_reg, b);
    assign crc16_val = crc16_add(bcrc_reg, held1_reg);

    // Frame engine: position tracking, checks and status.
    always_comb
    begin
        byte_index_next = byte_index_reg;
        exp_len_next    = exp_len_reg;
        hcrc_next       = hcrc_reg;
        bcrc_next       = bcrc_reg;
        held0_next      = held0_reg;
        held1_next      = held1_reg;
        addr_next       = addr_reg;
        exp_new         = exp_len_reg;
        res_end         = 1'b0;
        res_status      = ST_PROGRESS;
        res_len         = 8'd0;

        if (load && hunting)
        begin
            hcrc_next       = crc8_val;
            bcrc_next       = cfg.body_crc_seed;
            held0_next      = b;
            held1_next      = 8'd0;
            exp_len_next    = MAX_LEN;
            byte_index_next = 7'd1;
        end
        else if (load)
        begin
            // The body CRC runs two bytes behind, so the trailer stays out of it.
            if (byte_index_reg >= POS_BODY)
            begin
                bcrc_next = crc16_val;
            end
            held1_next = held0_reg;
            held0_next = b;
            if (byte_index_reg == POS_ADDR)
            begin
                addr_next = b;
            end
            if (byte_index_reg == POS_LEN)
            begin
                exp_new = b;
            end
            if (byte_index_reg < POS_HCRC)
            begin
                hcrc_next = crc8_val;
            end

            priority if (byte_index_reg == POS_LEN && b < MIN_LENGTH)
            begin
                res_end    = 1'b1;
                res_status = ST_SHORT;
            end
            else if (byte_index_reg == POS_HCRC && b != hcrc_reg)
            begin
                res_end    = 1'b1;
                res_status = ST_HDR_CRC;
            end
            else if (next_pos >= exp_new)
            begin
                res_end = 1'b1;
                if (held0_reg != bcrc_next[7:0] || b != bcrc_next[15:8])
                begin
                    res_status = ST_BODY_CRC;
                end
                else if (addr_next >= cfg.address_limit)
                begin
                    res_status = ST_BAD_ADDR;
                end
                else
                begin
                    res_status = ST_GOOD;
                end
            end
            else if (next_pos >= MAX_LEN)
            begin
                res_end    = 1'b1;
                res_status = ST_OVERFLOW;
            end
            else
            begin
                byte_index_next = next_pos[6:0];
            end

            if (res_end)
            begin
                res_len         = exp_new;
                byte_index_next = 7'd0;
                exp_len_next    = MAX_LEN;
            end
            else
            begin
                exp_len_next = exp_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg <= 7'd0;
            exp_len_reg    <= MAX_LEN;
            hcrc_reg       <= RST_HDR_SEED;
            bcrc_reg       <= RST_BODY_SEED;
            held0_reg      <= 8'd0;
            held1_reg      <= 8'd0;
            addr_reg       <= 8'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            byte_index_reg <= byte_index_next;
            exp_len_reg    <= exp_len_next;
            hcrc_reg       <= hcrc_next;
            bcrc_reg       <= bcrc_next;
            held0_reg      <= held0_next;
            held1_reg      <= held1_next;
            addr_reg       <= addr_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output register holding one result until it is transferred.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg   <= b;
            out_pos_reg    <= byte_index_reg;
            out_end_reg    <= res_end;
            out_status_reg <= res_status;
            out_len_reg    <= res_len;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign out_pos    = out_pos_reg;
    assign out_end    = out_end_reg;
    assign out_status = out_status_reg;
    assign out_len    = out_len_reg;

    // After a frame ends the engine goes back to hunting.
    a_end_rehunt: assert property (@(posedge clk) disable iff (!rst_n)
        (load && res_end) |=> (byte_index_reg == 7'd0))
        else $error("frame end did not return to hunting");

    // The position never reaches the buffer limit.
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, byte_index_reg} < MAX_LEN))
        else $error("byte position beyond buffer limit");

    // A held result carries a final status exactly when it ends a frame.
    a_status_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_end_reg == (out_status_reg != ST_PROGRESS)))
        else $error("status and frame end disagree");

    // The length field is zero on bytes inside a frame.
    a_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_end_reg) |-> (out_len_reg == 8'd0))
        else $error("declared length shown before frame end");

endmodule

[hdl/framed_bus_receiver_crc8_crc16_core.sv]
// A byte taken in is held in the two-entry queue, then in the output register; these let
// either side stall without losing a byte. Throughput: one byte per cycle unless the output
// stalls, set by the combinational frame engine and its CRC updates.
// Reset (rst_n, asynchronous, active low) empties the queue and output, loads register
// defaults and puts the engine into sync hunting; no clearing pass is needed.
module framed_bus_receiver_crc8_crc16_core
    import fbr_pkg::*;
#(
    parameter int MAX_FRAME = 100
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] frame_byte, [14:8] byte_position,
                                        // [22:15] declared_length, [23] zero
    output logic        m_axis_tlast,   // frame_end
    output logic [2:0]  m_axis_tuser,   // [2:0] frame_status
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    cfg_t       cfg_reg;
    q_entry_t   q_entry;
    logic       q_valid;
    logic       q_ready;
    logic [7:0] out_byte;
    logic [6:0] out_pos;
    status_t    out_status;
    logic [7:0] out_len;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_value      <= RST_SYNC_VALUE;
            cfg_reg.header_crc_seed <= RST_HDR_SEED;
            cfg_reg.body_crc_seed   <= RST_BODY_SEED;
            cfg_reg.address_limit   <= RST_ADDR_LIMIT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SYNC_VALUE: cfg_reg.sync_value      <= cfg_wdata[7:0];
                CFG_HDR_SEED:   cfg_reg.header_crc_seed <= cfg_wdata[7:0];
                CFG_BODY_SEED:  cfg_reg.body_crc_seed   <= cfg_wdata;
                CFG_ADDR_LIMIT: cfg_reg.address_limit   <= cfg_wdata[7:0];
                default:        cfg_reg.sync_value      <= cfg_reg.sync_value;
            endcase
        end
    end

    fbr_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .sync_value    (cfg_reg.sync_value),
        .q_valid       (q_valid),
        .q_entry       (q_entry),
        .q_ready       (q_ready)
    );

    fbr_back #(
        .MAX_FRAME (MAX_FRAME)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_valid    (q_valid),
        .q_entry    (q_entry),
        .q_ready    (q_ready),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_byte   (out_byte),
        .out_pos    (out_pos),
        .out_end    (m_axis_tlast),
        .out_status (out_status),
        .out_len    (out_len)
    );

    // Pack the result fields onto the stream.
    assign m_axis_tdata = {1'b0, out_len, out_pos, out_byte};
    assign m_axis_tuser = out_status;

endmodule
